@@ rtl/spke_pkg.sv @@
// Shared constants for the spaced-pattern k-mer extractor.
package spke_pkg;

    localparam int WINDOW_MAX_DEF = 12;
    localparam int KMER_MAX_DEF   = 32;

    localparam int HIST_W      = 64;
    localparam int LEN_W       = 6;
    localparam int COUNT_W     = 6;
    localparam int COUNT_LIMIT = 63;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int WLEN_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORTEST_KMER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONGEST_KMER  = 2'd2;

    localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RST = 4'd12;
    localparam logic [LEN_W-1:0]  SHORTEST_KMER_RST = 6'd1;
    localparam logic [LEN_W-1:0]  LONGEST_KMER_RST  = 6'd32;

    localparam logic MODE_SYMBOL      = 1'b0;
    localparam logic MODE_TABLE_WRITE = 1'b1;

endpackage

@@ rtl/spaced_pattern_kmer_extractor.sv @@
// Top level of the spaced-pattern k-mer extractor with its pattern table memory.

// Input items carry either a 2-bit base (tuser low) or a pattern table write (tuser high).
// The low class bits of the last window_length bases address a pattern table of
// 2^WINDOW_MAX one-bit entries held in a synchronous memory. After reset the block
// clears that memory in one pass over every entry and accepts no item until it is
// done; configuration writes are taken at any time. A base is accepted, then the
// table is read, then the block steps through each length from 1 up to the largest
// length it emits and then closes; a stalled output holds the stepping. Results
// leave through an output register, one per cycle while the output is not stalled,
// in ascending length, with tlast on the final one.
module spaced_pattern_kmer_extractor #(
    parameter int WINDOW_MAX = spke_pkg::WINDOW_MAX_DEF,
    parameter int KMER_MAX   = spke_pkg::KMER_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [spke_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [spke_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // Fields from bit 0: base_code[1:0], table_index[13:2], table_bit[14], zero[15].
    input  logic [15:0]                     i_s_axis_tdata,
    // Fields from bit 0: mode[0].
    input  logic                            i_s_axis_tuser,
    input  logic                            i_s_axis_tlast,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // Fields from bit 0: kmer_length[5:0], kmer_value[69:6], zero[71:70].
    output logic [71:0]                     o_m_axis_tdata,
    output logic                            o_m_axis_tlast
);

    localparam int DEPTH = 1 << WINDOW_MAX;
    localparam int PW    = $clog2(WINDOW_MAX + 1);
    localparam int KI    = (KMER_MAX > 1) ? $clog2(KMER_MAX) : 1;
    localparam int HW    = spke_pkg::HIST_W;
    localparam int LW    = spke_pkg::LEN_W;
    localparam int CW    = spke_pkg::COUNT_W;

    localparam logic [1:0] ST_CLR  = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_LOOK = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic                    r_mem [DEPTH];
    logic                    r_rd;

    logic [1:0]              r_state, n_state;
    logic [WINDOW_MAX-1:0]   r_clr;
    logic [spke_pkg::WLEN_W-1:0] r_wl;
    logic [LW-1:0]           r_sk, r_lk;

    logic [WINDOW_MAX-1:0]   r_class, n_class;
    logic [HW-1:0]           r_hist, n_hist;
    logic [KMER_MAX-1:0]     r_marks, n_marks;
    logic [CW-1:0]           r_count, n_count;
    logic [KMER_MAX-1:0]     r_pend, n_pend;
    logic [KI-1:0]           r_kidx;
    logic                    r_seq_end;

    logic                    r_ovalid;
    logic [LW-1:0]           r_olen;
    logic [HW-1:0]           r_oval;
    logic                    r_olast;

    logic [PW-1:0]           w_p;
    logic                    w_accept, w_sym, w_twr;
    logic                    w_mem_we, w_mem_wd;
    logic [WINDOW_MAX-1:0]   w_mem_wa, w_mem_ra;
    logic                    w_hit;
    logic [KMER_MAX-1:0]     w_marks_hit, w_pend_look;
    logic                    w_cur, w_out_free, w_load, w_finish;
    logic [KMER_MAX-1:0]     w_pend_clr;
    logic [6:0]              w_k7, w_p7, w_sh;
    logic [HW-1:0]           w_kmask, w_kval;

    always_comb begin
        if (int'(r_wl) > WINDOW_MAX) begin
            w_p = PW'(WINDOW_MAX);
        end else if (r_wl == '0) begin
            w_p = PW'(1);
        end else begin
            w_p = PW'(r_wl);
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_sym    = w_accept && (i_s_axis_tuser == spke_pkg::MODE_SYMBOL);
    assign w_twr    = w_accept && (i_s_axis_tuser == spke_pkg::MODE_TABLE_WRITE);

    assign n_class  = (r_class << 1) | WINDOW_MAX'(i_s_axis_tdata[0]);
    assign w_mem_ra = n_class & ~({WINDOW_MAX{1'b1}} << w_p);

    always_comb begin
        if (r_state == ST_CLR) begin
            w_mem_we = 1'b1;
            w_mem_wa = r_clr;
            w_mem_wd = 1'b0;
        end else begin
            w_mem_we = w_twr;
            w_mem_wa = WINDOW_MAX'({{WINDOW_MAX{1'b0}}, i_s_axis_tdata[13:2]});
            w_mem_wd = i_s_axis_tdata[14];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_wa] <= w_mem_wd;
        end
        r_rd <= r_mem[w_mem_ra];
    end

    assign w_hit       = (int'(r_count) >= int'(w_p)) && r_rd;
    assign w_marks_hit = r_marks | (w_hit ? (KMER_MAX'(1) << (w_p - PW'(1))) : '0);

    always_comb begin
        int kmin, kmax, k;
        kmin = (r_sk == '0) ? 1 : int'(r_sk);
        kmax = (int'(r_lk) > KMER_MAX) ? KMER_MAX : int'(r_lk);
        for (int j = 0; j < KMER_MAX; j++) begin
            k = j + 1;
            w_pend_look[j] = (k >= kmin) && (k <= kmax) &&
                             ((k <= int'(w_p)) ? w_hit : w_marks_hit[j]);
        end
    end

    assign w_cur      = r_pend[r_kidx];
    assign w_pend_clr = r_pend & ~(KMER_MAX'(1) << r_kidx);
    assign w_out_free = !r_ovalid || i_m_axis_tready;
    assign w_load     = (r_state == ST_EMIT) && (r_pend != '0) && w_cur && w_out_free;
    assign w_finish   = (r_state == ST_EMIT) && (r_pend == '0);

    assign w_k7    = 7'(r_kidx) + 7'd1;
    assign w_p7    = 7'(w_p);
    assign w_sh    = (w_k7 <= w_p7) ? ((w_p7 - w_k7) << 1) : 7'd0;
    assign w_kmask = {HW{1'b1}} >> (7'd64 - (w_k7 << 1));
    assign w_kval  = (r_hist >> w_sh) & w_kmask;

    always_comb begin
        n_state = r_state;
        n_hist  = r_hist;
        n_marks = r_marks;
        n_count = r_count;
        n_pend  = r_pend;
        case (r_state)
            ST_CLR: begin
                if (r_clr == {WINDOW_MAX{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_sym) begin
                    n_hist  = {r_hist[HW-3:0], i_s_axis_tdata[1:0]};
                    n_marks = r_marks << 1;
                    n_count = (int'(r_count) < spke_pkg::COUNT_LIMIT) ? r_count + CW'(1)
                                                                     : r_count;
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_marks = w_marks_hit;
                n_pend  = w_pend_look;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (r_pend == '0) begin
                    n_state = ST_IDLE;
                    if (r_seq_end) begin
                        n_hist  = '0;
                        n_marks = '0;
                        n_count = '0;
                    end
                end else if (w_load) begin
                    n_pend = w_pend_clr;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_clr     <= '0;
            r_wl      <= spke_pkg::WINDOW_LENGTH_RST;
            r_sk      <= spke_pkg::SHORTEST_KMER_RST;
            r_lk      <= spke_pkg::LONGEST_KMER_RST;
            r_class   <= '0;
            r_hist    <= '0;
            r_marks   <= '0;
            r_count   <= '0;
            r_pend    <= '0;
            r_kidx    <= '0;
            r_seq_end <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hist  <= n_hist;
            r_marks <= n_marks;
            r_count <= n_count;
            r_pend  <= n_pend;
            if (r_state == ST_CLR) begin
                r_clr <= r_clr + WINDOW_MAX'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    spke_pkg::REG_WINDOW_LENGTH: r_wl <= i_cfg_data[spke_pkg::WLEN_W-1:0];
                    spke_pkg::REG_SHORTEST_KMER: r_sk <= i_cfg_data;
                    spke_pkg::REG_LONGEST_KMER:  r_lk <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_sym) begin
                r_class   <= n_class;
                r_seq_end <= i_s_axis_tlast;
            end else if (w_finish && r_seq_end) begin
                r_class <= '0;
            end
            if (r_state == ST_LOOK) begin
                r_kidx <= '0;
            end else if (r_state == ST_EMIT && (!w_cur || w_load)) begin
                r_kidx <= r_kidx + KI'(1);
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_olen  <= LW'(r_kidx) + LW'(1);
            r_oval  <= w_kval;
            r_olast <= (w_pend_clr == '0);
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {2'b00, r_oval, r_olen};
    assign o_m_axis_tlast  = r_olast;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLR) |-> !o_s_axis_tready)
        else $error("item accepted during the table clearing pass");

    a_symbol_reads_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sym |=> (r_state == ST_LOOK))
        else $error("symbol item did not move on to the table lookup");

    a_emit_done_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_pend == '0) |=> (r_state == ST_IDLE))
        else $error("emission did not close once no k-mer was pending");

    a_length_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[LW-1:0] != '0))
        else $error("result item with zero k-mer length");

endmodule
